FILE: src/lt2fc_pkg.sv
// Shared types, constants and tables for the two-flag centroid locator.
package lt2fc_pkg;

   localparam int COORD_W      = 16;
   localparam int CFG_W        = 10;
   localparam int HEAD_W       = 15;
   localparam int STAT_W       = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int K_W          = 19;
   localparam int CORDIC_STEPS = 14;
   localparam int STEP_W       = 4;
   localparam int CX_W         = 28;
   localparam int Z_W          = 16;
   localparam int HEAD_MAX     = 12868;

   // round(2^20 * 4 / (3 pi))
   localparam logic [K_W-1:0] PUSH_K = K_W'(445029);

   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_RADIUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_GAP  = 2'd2;

   localparam logic [CFG_W-1:0] LARGE_RADIUS_RST = 10'd100;
   localparam logic [CFG_W-1:0] SMALL_RADIUS_RST = 10'd40;
   localparam logic [CFG_W-1:0] CLUSTER_GAP_RST  = 10'd50;

   typedef enum logic [1:0] {
      JOB_PX = 2'd0,
      JOB_PY = 2'd1,
      JOB_MX = 2'd2,
      JOB_MY = 2'd3
   } lt2fc_job_type;

   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_ACC   = 15'b000000000000010,
      ST_LOAD  = 15'b000000000000100,
      ST_SQX   = 15'b000000000001000,
      ST_SQY   = 15'b000000000010000,
      ST_RT_GO = 15'b000000000100000,
      ST_RT_W  = 15'b000000001000000,
      ST_RK    = 15'b000000010000000,
      ST_PMUL  = 15'b000000100000000,
      ST_DV_GO = 15'b000001000000000,
      ST_DV_W  = 15'b000010000000000,
      ST_CENT  = 15'b000100000000000,
      ST_HD_GO = 15'b001000000000000,
      ST_HD_W  = 15'b010000000000000,
      ST_OUT   = 15'b100000000000000
   } lt2fc_state_type;

   typedef struct packed {
      logic          take;
      logic          acc;
      logic          load;
      logic          cl;
      logic          empty_mark;
      logic          sqx;
      logic          sqy;
      logic          sqrt_start;
      logic          rk;
      logic          pmul;
      lt2fc_job_type job;
      logic          div_start;
      logic          div_take;
      logic          cent;
      logic          cordic_start;
      logic          out_load;
   } lt2fc_cmd_type;

   typedef struct packed {
      logic end_flag;
      logic cl_empty;
      logic rt_busy;
      logic div_busy;
      logic cor_busy;
      logic out_busy;
   } lt2fc_stat_type;

   // atan(2^-i) in Q2.13
   function automatic logic signed [Z_W-1:0] atan_q13(input logic [STEP_W-1:0] i);
      logic signed [Z_W-1:0] a;
      case (i)
         4'd0:    a = 16'sd6434;
         4'd1:    a = 16'sd3798;
         4'd2:    a = 16'sd2007;
         4'd3:    a = 16'sd1019;
         4'd4:    a = 16'sd511;
         4'd5:    a = 16'sd256;
         4'd6:    a = 16'sd128;
         4'd7:    a = 16'sd64;
         4'd8:    a = 16'sd32;
         4'd9:    a = 16'sd16;
         4'd10:   a = 16'sd8;
         4'd11:   a = 16'sd4;
         4'd12:   a = 16'sd2;
         4'd13:   a = 16'sd1;
         default: a = 16'sd0;
      endcase
      return a;
   endfunction

endpackage

FILE: src/lt2fc_divider.sv
// Restoring serial divider, one quotient bit per cycle, signed result.
module lt2fc_divider #(
   parameter int NUM_W = 56,
   parameter int DEN_W = 38,
   parameter int Q_W   = 26
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      num,
   input  logic [DEN_W-1:0]      den,
   input  logic                  neg,
   output logic                  busy,
   output logic signed [Q_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [DEN_W:0]   cand;
   logic             qbit;

   always_comb begin
      cand = {rem_ff, quo_ff[NUM_W-1]};
      qbit = (cand >= {1'b0, den_ff});
      rem_in = qbit ? DEN_W'(cand - {1'b0, den_ff}) : cand[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NUM_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
         neg_ff <= neg;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = neg_ff ? -$signed({1'b0, quo_ff[Q_W-2:0]}) : $signed({1'b0, quo_ff[Q_W-2:0]});

endmodule

FILE: src/lt2fc_datapath.sv
// Datapath: point accumulation, root, push, means, centres, heading, result register.
module lt2fc_datapath #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [lt2fc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lt2fc_pkg::CFG_W-1:0]            csr_wdata,
   input  logic [2*lt2fc_pkg::COORD_W-1:0]        req_tdata,
   input  logic                                   req_tlast,
   input  lt2fc_pkg::lt2fc_cmd_type               cmd,
   output lt2fc_pkg::lt2fc_stat_type              stat,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [4*lt2fc_pkg::COORD_W+15:0]       rsp_tdata,
   output logic [lt2fc_pkg::STAT_W-1:0]           rsp_tuser
);
   import lt2fc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = COORD_W + $clog2(MAX_POINTS);
   localparam int SQ_W   = 2 * SUM_W;
   localparam int RT_W   = SUM_W + 2;
   localparam int RTC_W  = $clog2(SUM_W);
   localparam int RK_W   = CFG_W + K_W;
   localparam int PROD_W = RK_W + SUM_W;
   localparam int DEN_W  = SUM_W + 12;
   localparam int NUM_W  = PROD_W + 1;
   localparam int ACC_W  = COORD_W + 10;
   localparam int DIST_W = 2 * COORD_W + 2;
   localparam int THR_W  = 2 * (CFG_W + 1);
   localparam logic signed [ACC_W-8:0] C_HI = (ACC_W-7)'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [ACC_W-8:0] C_LO = -C_HI - (ACC_W-7)'(1);
   localparam logic signed [Z_W-1:0]   HMAX_Z = Z_W'(HEAD_MAX);
   localparam logic [CNT_W-1:0]        CNT_MAX = CNT_W'(MAX_POINTS);

   // mean+push in Q8 -> mm, rounded half away from zero, saturated
   function automatic logic signed [COORD_W-1:0] cent_round(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0]          mag;
      logic [ACC_W-9:0]          q;
      logic signed [ACC_W-8:0]   s;
      logic signed [COORD_W-1:0] r;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      q   = (ACC_W-8)'((mag + ACC_W'(128)) >> 8);
      s   = v[ACC_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (s > C_HI)      r = C_HI[COORD_W-1:0];
      else if (s < C_LO) r = C_LO[COORD_W-1:0];
      else               r = s[COORD_W-1:0];
      return r;
   endfunction

   // configuration
   logic [CFG_W-1:0] large_ff, small_ff, gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         large_ff <= LARGE_RADIUS_RST;
         small_ff <= SMALL_RADIUS_RST;
         gap_ff   <= CLUSTER_GAP_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LARGE_RADIUS: large_ff <= csr_wdata;
            CSR_SMALL_RADIUS: small_ff <= csr_wdata;
            CSR_CLUSTER_GAP:  gap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // point intake and join test
   logic signed [COORD_W-1:0] in_x, in_y;
   logic signed [COORD_W-1:0] pt_x_ff, pt_y_ff, prior_x_ff, prior_y_ff;
   logic                      end_ff, prior_valid_ff, active_ff;
   logic signed [COORD_W:0]   jdx, jdy;
   logic signed [DIST_W-1:0]  jdx2, jdy2;
   logic [CFG_W:0]            thr;
   logic [DIST_W-1:0]         dist_ff;
   logic [THR_W-1:0]          thr_ff;
   logic                      toggle, act_next;

   assign in_x = req_tdata[COORD_W-1:0];
   assign in_y = req_tdata[2*COORD_W-1:COORD_W];
   assign jdx  = (COORD_W+1)'(in_x) - (COORD_W+1)'(prior_x_ff);
   assign jdy  = (COORD_W+1)'(in_y) - (COORD_W+1)'(prior_y_ff);
   assign jdx2 = jdx * jdx;
   assign jdy2 = jdy * jdy;
   assign thr  = {1'b0, large_ff} + {1'b0, gap_ff};
   assign toggle   = prior_valid_ff && !(dist_ff < DIST_W'(thr_ff));
   assign act_next = active_ff ^ toggle;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pt_x_ff <= in_x;
         pt_y_ff <= in_y;
         end_ff  <= req_tlast;
         dist_ff <= $unsigned(jdx2) + $unsigned(jdy2);
         thr_ff  <= thr * thr;
      end
   end

   // cluster accumulators
   logic signed [SUM_W-1:0] first_sx_ff, first_sy_ff, second_sx_ff, second_sy_ff;
   logic [CNT_W-1:0]        first_n_ff, second_n_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         prior_x_ff     <= '0;
         prior_y_ff     <= '0;
         prior_valid_ff <= 1'b0;
         active_ff      <= 1'b0;
         first_sx_ff    <= '0;
         first_sy_ff    <= '0;
         second_sx_ff   <= '0;
         second_sy_ff   <= '0;
         first_n_ff     <= '0;
         second_n_ff    <= '0;
      end else if (cmd.acc) begin
         prior_x_ff     <= pt_x_ff;
         prior_y_ff     <= pt_y_ff;
         prior_valid_ff <= 1'b1;
         active_ff      <= act_next;
         if (!act_next) begin
            if (first_n_ff < CNT_MAX) begin
               first_sx_ff <= first_sx_ff + SUM_W'(pt_x_ff);
               first_sy_ff <= first_sy_ff + SUM_W'(pt_y_ff);
               first_n_ff  <= first_n_ff + 1'b1;
            end
         end else begin
            if (second_n_ff < CNT_MAX) begin
               second_sx_ff <= second_sx_ff + SUM_W'(pt_x_ff);
               second_sy_ff <= second_sy_ff + SUM_W'(pt_y_ff);
               second_n_ff  <= second_n_ff + 1'b1;
            end
         end
      end
   end

   // working copy of the cluster being located
   logic signed [SUM_W-1:0] w_sx_ff, w_sy_ff;
   logic [CNT_W-1:0]        w_n_ff;
   logic [CFG_W-1:0]        w_r_ff;
   logic [SUM_W-1:0]        ax, ay;
   logic [SQ_W-1:0]         sq_ff;

   assign ax = w_sx_ff[SUM_W-1] ? SUM_W'(-w_sx_ff) : SUM_W'(w_sx_ff);
   assign ay = w_sy_ff[SUM_W-1] ? SUM_W'(-w_sy_ff) : SUM_W'(w_sy_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_sx_ff <= cmd.cl ? second_sx_ff : first_sx_ff;
         w_sy_ff <= cmd.cl ? second_sy_ff : first_sy_ff;
         w_n_ff  <= cmd.cl ? second_n_ff : first_n_ff;
         w_r_ff  <= cmd.cl ? small_ff : large_ff;
      end
      if (cmd.sqx) sq_ff <= ax * ax;
      else if (cmd.sqy) sq_ff <= sq_ff + ay * ay;
   end

   // digit-by-digit square root, two radicand bits per cycle
   logic [RT_W-1:0]  rt_rem_ff;
   logic [SUM_W-1:0] rt_root_ff;
   logic [SQ_W-1:0]  rt_src_ff;
   logic [RTC_W-1:0] rt_cnt_ff;
   logic             rt_busy_ff;
   logic [RT_W-1:0]  rt_cand, rt_trial;

   assign rt_cand  = {rt_rem_ff[RT_W-3:0], rt_src_ff[SQ_W-1:SQ_W-2]};
   assign rt_trial = {rt_root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_busy_ff <= 1'b0;
         rt_cnt_ff  <= '0;
      end else if (cmd.sqrt_start) begin
         rt_busy_ff <= 1'b1;
         rt_cnt_ff  <= RTC_W'(SUM_W - 1);
      end else if (rt_busy_ff) begin
         rt_cnt_ff <= rt_cnt_ff - 1'b1;
         if (rt_cnt_ff == '0) rt_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rt_rem_ff  <= '0;
         rt_root_ff <= '0;
         rt_src_ff  <= sq_ff;
      end else if (rt_busy_ff) begin
         rt_src_ff <= {rt_src_ff[SQ_W-3:0], 2'b00};
         if (rt_cand >= rt_trial) begin
            rt_rem_ff  <= rt_cand - rt_trial;
            rt_root_ff <= {rt_root_ff[SUM_W-2:0], 1'b1};
         end else begin
            rt_rem_ff  <= rt_cand;
            rt_root_ff <= {rt_root_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // push numerators and means go through the shared divider
   logic [RK_W-1:0]          rk_ff;
   logic                     zero_ff;
   logic signed [SUM_W-1:0]  nx, ny, nsel;
   logic signed [PROD_W:0]   prod_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [SUM_W-1:0]         mag_eff;
   logic [PROD_W-1:0]        prod_mag;
   logic [NUM_W-1:0]         div_num;
   logic                     div_busy;
   logic signed [ACC_W-1:0]  div_q;
   logic signed [ACC_W-1:0]  px_ff, py_ff, mx_ff, my_ff;

   assign nx       = zero_ff ? SUM_W'(1) : w_sx_ff;
   assign ny       = zero_ff ? SUM_W'(0) : w_sy_ff;
   assign nsel     = (cmd.job == JOB_PX) ? nx : ny;
   assign mag_eff  = zero_ff ? SUM_W'(1) : rt_root_ff;
   assign prod_mag = prod_ff[PROD_W] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign div_num  = NUM_W'(prod_mag) + NUM_W'(den_ff >> 1);

   always_ff @(posedge clock) begin
      if (cmd.rk) begin
         rk_ff   <= w_r_ff * PUSH_K;
         zero_ff <= (rt_root_ff == '0);
      end
      if (cmd.pmul) begin
         case (cmd.job)
            JOB_PX, JOB_PY: begin
               prod_ff <= $signed({1'b0, rk_ff}) * nsel;
               den_ff  <= {mag_eff, 12'd0};
            end
            JOB_MX: begin
               prod_ff <= (PROD_W+1)'(w_sx_ff) <<< 8;
               den_ff  <= DEN_W'(w_n_ff);
            end
            JOB_MY: begin
               prod_ff <= (PROD_W+1)'(w_sy_ff) <<< 8;
               den_ff  <= DEN_W'(w_n_ff);
            end
            default: ;
         endcase
      end
      if (cmd.div_take) begin
         case (cmd.job)
            JOB_PX:  px_ff <= div_q;
            JOB_PY:  py_ff <= div_q;
            JOB_MX:  mx_ff <= div_q;
            JOB_MY:  my_ff <= div_q;
            default: ;
         endcase
      end
   end

   lt2fc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (ACC_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (den_ff),
      .neg   (prod_ff[PROD_W]),
      .busy  (div_busy),
      .quo   (div_q)
   );

   // centres and empty status
   logic signed [COORD_W-1:0] c1x_ff, c1y_ff, c2x_ff, c2y_ff;
   logic [STAT_W-1:0]         status_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         status_ff <= '0;
      end else if (cmd.empty_mark) begin
         status_ff[cmd.cl] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.empty_mark) begin
         if (cmd.cl) begin
            c2x_ff <= '0;
            c2y_ff <= '0;
         end else begin
            c1x_ff <= '0;
            c1y_ff <= '0;
         end
      end else if (cmd.cent) begin
         if (cmd.cl) begin
            c2x_ff <= cent_round(mx_ff + px_ff);
            c2y_ff <= cent_round(my_ff + py_ff);
         end else begin
            c1x_ff <= cent_round(mx_ff + px_ff);
            c1y_ff <= cent_round(my_ff + py_ff);
         end
      end
   end

   // CORDIC vectoring for the heading, one micro-rotation per cycle
   logic signed [COORD_W:0]   cdx, cdy;
   logic signed [CX_W-1:0]    ex, ey, fx, fy;
   logic signed [CX_W-1:0]    cx_ff, cy_ff, xs, ys;
   logic signed [Z_W-1:0]     z_ff;
   logic [STEP_W-1:0]         cstep_ff;
   logic                      cor_busy_ff;
   logic                      head_special;
   logic signed [HEAD_W-1:0]  head_v;

   assign cdx = (COORD_W+1)'(c1x_ff) - (COORD_W+1)'(c2x_ff);
   assign cdy = (COORD_W+1)'(c1y_ff) - (COORD_W+1)'(c2y_ff);
   assign ex  = CX_W'(cdx);
   assign ey  = CX_W'(cdy);
   assign fx  = cdx[COORD_W] ? -ex : ex;
   assign fy  = cdx[COORD_W] ? -ey : ey;
   assign xs  = cx_ff >>> cstep_ff;
   assign ys  = cy_ff >>> cstep_ff;
   assign head_special = (status_ff != '0) || (cdx == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_busy_ff <= 1'b0;
         cstep_ff    <= '0;
      end else if (cmd.cordic_start) begin
         cor_busy_ff <= !head_special;
         cstep_ff    <= '0;
      end else if (cor_busy_ff) begin
         cstep_ff <= cstep_ff + 1'b1;
         if (cstep_ff == STEP_W'(CORDIC_STEPS - 1)) cor_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cordic_start) begin
         cx_ff <= fx <<< 8;
         cy_ff <= fy <<< 8;
         if (status_ff != '0)   z_ff <= '0;
         else if (cdx != '0)    z_ff <= '0;
         else if (cdy > 0)      z_ff <= HMAX_Z;
         else if (cdy < 0)      z_ff <= -HMAX_Z;
         else                   z_ff <= '0;
      end else if (cor_busy_ff) begin
         if (!cy_ff[CX_W-1]) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            z_ff  <= z_ff + atan_q13(cstep_ff);
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            z_ff  <= z_ff - atan_q13(cstep_ff);
         end
      end
   end

   always_comb begin
      if (z_ff > HMAX_Z)       head_v = HMAX_Z[HEAD_W-1:0];
      else if (z_ff < -HMAX_Z) head_v = -HMAX_Z[HEAD_W-1:0];
      else                     head_v = z_ff[HEAD_W-1:0];
   end

   // result register
   logic                          rsp_valid_ff;
   logic [4*COORD_W+15:0]         rsp_data_ff;
   logic [STAT_W-1:0]             rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {1'b0, head_v, c2y_ff, c2x_ff, c1y_ff, c1x_ff};
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign stat.end_flag = end_ff;
   assign stat.cl_empty = cmd.cl ? (second_n_ff == '0) : (first_n_ff == '0);
   assign stat.rt_busy  = rt_busy_ff;
   assign stat.div_busy = div_busy;
   assign stat.cor_busy = cor_busy_ff;
   assign stat.out_busy = rsp_valid_ff;

endmodule

FILE: src/lt2fc_controller.sv
// Controller: sequences point intake and the end-of-scan locate steps.
module lt2fc_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  lt2fc_pkg::lt2fc_stat_type   stat,
   output lt2fc_pkg::lt2fc_cmd_type    cmd
);
   import lt2fc_pkg::*;

   lt2fc_state_type state_ff, state_in;
   logic            cl_ff, cl_in;
   lt2fc_job_type   job_ff, job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cl_ff    <= 1'b0;
         job_ff   <= JOB_PX;
      end else begin
         state_ff <= state_in;
         cl_ff    <= cl_in;
         job_ff   <= job_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cl_in    = cl_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.cl   = cl_ff;
      cmd.job  = job_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = req_tvalid;
            if (req_tvalid) state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            cl_in   = 1'b0;
            state_in = stat.end_flag ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (stat.cl_empty) begin
               cmd.empty_mark = 1'b1;
               cl_in    = 1'b1;
               state_in = cl_ff ? ST_HD_GO : ST_LOAD;
            end else begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            cmd.sqx  = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sqy  = 1'b1;
            state_in = ST_RT_GO;
         end
         ST_RT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in = ST_RT_W;
         end
         ST_RT_W: begin
            if (!stat.rt_busy) state_in = ST_RK;
         end
         ST_RK: begin
            cmd.rk   = 1'b1;
            job_in   = JOB_PX;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.pmul = 1'b1;
            state_in = ST_DV_GO;
         end
         ST_DV_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DV_W;
         end
         ST_DV_W: begin
            if (!stat.div_busy) begin
               cmd.div_take = 1'b1;
               if (job_ff == JOB_MY) begin
                  state_in = ST_CENT;
               end else begin
                  job_in   = lt2fc_job_type'(job_ff + 2'd1);
                  state_in = ST_PMUL;
               end
            end
         end
         ST_CENT: begin
            cmd.cent = 1'b1;
            cl_in    = 1'b1;
            state_in = cl_ff ? ST_HD_GO : ST_LOAD;
         end
         ST_HD_GO: begin
            cmd.cordic_start = 1'b1;
            state_in = ST_HD_W;
         end
         ST_HD_W: begin
            if (!stat.cor_busy) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

FILE: src/lidar_two_flag_centroid_locator_unit.sv
// Top level of the lidar two-flag centroid locator.
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata: point_x, point_y; tlast: scan_end
//  rsp      out  rsp_tvalid/tready    tdata: centres, heading; tuser: locate_status
//  csr      in   csr_write_en         csr_index, csr_wdata
//
// A point word is captured with the distance squares, then accumulated; the next
// word is accepted only after the accumulate. The scan-end word adds the locate
// sequence, which runs each filled cluster through the shared serial divider.
// Reset is synchronous and clears all scan state.
// A pending result sits in its own register; a later scan end waits for it.
module lidar_two_flag_centroid_locator_unit #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [lt2fc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lt2fc_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y
   input  logic [2*lt2fc_pkg::COORD_W-1:0]     req_tdata,
   // scan_end
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // first_center_x, first_center_y, second_center_x, second_center_y,
   // heading_angle, zero pad
   output logic [4*lt2fc_pkg::COORD_W+15:0]    rsp_tdata,
   // locate_status
   output logic [lt2fc_pkg::STAT_W-1:0]        rsp_tuser
);
   import lt2fc_pkg::*;

   lt2fc_cmd_type  cmd;
   lt2fc_stat_type stat;

   lt2fc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lt2fc_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

FILE: test/lidar_two_flag_centroid_locator_unit_tb.sv
// Testbench for the lidar two-flag centroid locator: directed and random scans against a predictor.
`timescale 1ns / 1ps

module lidar_two_flag_centroid_locator_unit_tb;
   import lt2fc_pkg::*;

   localparam int MAX_PTS      = 1024;
   localparam int SETTLE       = 700;
   localparam int WATCH_LIMIT  = 20000;

   typedef struct packed {
      logic signed [15:0] c1x;
      logic signed [15:0] c1y;
      logic signed [15:0] c2x;
      logic signed [15:0] c2y;
      logic signed [14:0] head;
      logic [1:0]         status;
   } locate_word_type;

   typedef struct {
      int              x;
      int              y;
      bit              last;
      bit              typed;
      locate_word_type want;
   } point_row_type;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   csr_write_en = 0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [2*COORD_W-1:0]   req_tdata = '0;
   logic                   req_tlast = 0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [4*COORD_W+15:0]  rsp_tdata;
   logic [STAT_W-1:0]      rsp_tuser;

   lidar_two_flag_centroid_locator_unit #(.MAX_POINTS(MAX_PTS)) DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   longint large_r, small_r, join_gap;
   longint last_x, last_y, sum1x, sum1y, sum2x, sum2y;
   int     cnt1, cnt2;
   bit     have_last, in_second;
   locate_word_type centres_due[$];
   point_row_type   dir_rows[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;

   function automatic longint round_div(longint a, longint b);
      longint m, q;
      m = a < 0 ? -a : a;
      q = (m + b / 2) / b;
      return a < 0 ? -q : q;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic longint sat16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic void flag_centre(longint sx, longint sy, int n, longint r,
                                       output longint cx, output longint cy);
      longint mag, rk, px, py;
      mag = int_sqrt(sx * sx + sy * sy);
      rk = r * 445029;
      if (mag == 0) begin
         px = round_div(rk, 4096);
         py = 0;
      end else begin
         px = round_div(rk * sx, mag * 4096);
         py = round_div(rk * sy, mag * 4096);
      end
      cx = sat16(round_div(round_div(sx * 256, n) + px, 256));
      cy = sat16(round_div(round_div(sy * 256, n) + py, 256));
   endfunction

   function automatic longint yaw_q13(longint dx, longint dy);
      longint x, y, z, xs, ys;
      longint atab[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      z = 0;
      if (dx == 0) return dy > 0 ? HEAD_MAX : (dy < 0 ? -HEAD_MAX : 0);
      if (dx < 0) begin
         dx = -dx;
         dy = -dy;
      end
      x = dx * 256;
      y = dy * 256;
      for (int i = 0; i < 14; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atab[i];
         end else begin
            x -= ys; y += xs; z -= atab[i];
         end
      end
      return z > HEAD_MAX ? HEAD_MAX : (z < -HEAD_MAX ? -HEAD_MAX : z);
   endfunction

   function automatic void clear_scan();
      last_x = 0; last_y = 0; have_last = 0; in_second = 0;
      sum1x = 0; sum1y = 0; sum2x = 0; sum2y = 0; cnt1 = 0; cnt2 = 0;
   endfunction

   // returns 1 when the point closes a scan; w then holds the result
   function automatic bit add_point(longint x, longint y, bit last, output locate_word_type w);
      longint dx, dy, t, c1x, c1y, c2x, c2y, hd;
      c1x = 0; c1y = 0; c2x = 0; c2y = 0; hd = 0;
      w = '0;
      if (have_last) begin
         dx = x - last_x;
         dy = y - last_y;
         t = large_r + join_gap;
         if (!(dx * dx + dy * dy < t * t)) in_second = ~in_second;
      end
      if (!in_second) begin
         if (cnt1 < MAX_PTS) begin
            sum1x += x; sum1y += y; cnt1++;
         end
      end else if (cnt2 < MAX_PTS) begin
         sum2x += x; sum2y += y; cnt2++;
      end
      last_x = x; last_y = y; have_last = 1;
      if (!last) return 0;
      if (cnt1 == 0) w.status[0] = 1;
      else flag_centre(sum1x, sum1y, cnt1, large_r, c1x, c1y);
      if (cnt2 == 0) w.status[1] = 1;
      else flag_centre(sum2x, sum2y, cnt2, small_r, c2x, c2y);
      if (w.status == 0) hd = yaw_q13(c1x - c2x, c1y - c2y);
      w.c1x = c1x[15:0]; w.c1y = c1y[15:0];
      w.c2x = c2x[15:0]; w.c2y = c2y[15:0];
      w.head = hd[14:0];
      clear_scan();
      return 1;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (quiet || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // valid stays up after the accepting edge until the next falling edge
   task automatic send_point(int x, int y, bit last, bit typed = 0,
                             locate_word_type want = '0);
      locate_word_type w;
      int              g;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {y[15:0], x[15:0]};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (add_point(x, y, last, w)) centres_due.push_back(typed ? want : w);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val[CFG_W-1:0];
      @(negedge clock);
      csr_write_en <= 0;
      case (idx)
         CSR_LARGE_RADIUS: large_r = val;
         CSR_SMALL_RADIUS: small_r = val;
         default:          join_gap = val;
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (centres_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic int clip16(int v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   // clusters of nearby points with random content, plus some noise
   task automatic random_scan(int npts);
      int cx, cy, jit, span;
      span = ($urandom_range(0, 3) == 0) ? 32000 : 3000;
      jit = int'((large_r + join_gap) / 4);
      cx = $urandom_range(0, 2 * span) - span;
      cy = $urandom_range(0, 2 * span) - span;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < npts; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            cx = $urandom_range(0, 2 * span) - span;
            cy = $urandom_range(0, 2 * span) - span;
         end
         if ($urandom_range(0, 9) == 0)
            send_point($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                       i == npts - 1);
         else
            send_point(clip16(cx + $urandom_range(0, 2 * jit) - jit),
                       clip16(cy + $urandom_range(0, 2 * jit) - jit), i == npts - 1);
      end
      quiet = 0;
   endtask

   task automatic add_row(int x, int y, bit last, bit typed = 0, locate_word_type want = '0);
      point_row_type r;
      r.x = x; r.y = y; r.last = last; r.typed = typed; r.want = want;
      dir_rows.push_back(r);
   endtask

   // response side stalls
   always @(negedge clock) rsp_tready <= (gap_len() == 0);

   // result checker
   always @(posedge clock) begin
      locate_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tdata[63:48],
                rsp_tdata[78:64], rsp_tuser};
         if (centres_due.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = centres_due.pop_front();
            if (got.c1x !== want.c1x) begin
               $display("%0t: first_center_x exp %0d got %0d", $time, want.c1x, got.c1x);
               errors++;
            end
            if (got.c1y !== want.c1y) begin
               $display("%0t: first_center_y exp %0d got %0d", $time, want.c1y, got.c1y);
               errors++;
            end
            if (got.c2x !== want.c2x) begin
               $display("%0t: second_center_x exp %0d got %0d", $time, want.c2x, got.c2x);
               errors++;
            end
            if (got.c2y !== want.c2y) begin
               $display("%0t: second_center_y exp %0d got %0d", $time, want.c2y, got.c2y);
               errors++;
            end
            if (got.head !== want.head) begin
               $display("%0t: heading_angle exp %0d got %0d", $time, want.head, got.head);
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t: locate_status exp %0d got %0d", $time, want.status,
                        got.status);
               errors++;
            end
         end
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("lidar_two_flag_centroid_locator_unit regression: fail");
         $finish;
      end
   end

   initial begin
      large_r = 100; small_r = 40; join_gap = 50;
      clear_scan();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // lone point at origin: push along +x only, second cluster empty
      add_row(0, 0, 1, 1, '{c1x: 42, c1y: 0, c2x: 0, c2y: 0, head: 0, status: 2});
      // coordinate extremes, each point far from the previous one but for a repeat at the end
      add_row(32767, 32767, 0);
      add_row(-32768, -32768, 0);
      add_row(32767, -32768, 0);
      add_row(-32768, 32767, 1);
      add_row(-32768, -32768, 0);
      add_row(-32768, -32768, 1);
      // vertical line between the centres
      add_row(0, 1000, 0);
      add_row(0, 5000, 1);
      add_row(0, -1000, 0);
      add_row(0, -5000, 1);
      // first cluster mean at origin
      add_row(-50, 0, 0);
      add_row(50, 0, 0);
      add_row(0, 3000, 1);
      // joins just inside the threshold, then a step exactly at it opens the second cluster
      add_row(10, 10, 0);
      add_row(159, 10, 0);
      add_row(30, 30, 0);
      add_row(30, 180, 1);
      foreach (dir_rows[i])
         send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last, dir_rows[i].typed,
                    dir_rows[i].want);

      // count saturation: one long scan of close points
      quiet = 1;
      for (int i = 0; i < 1100; i++)
         send_point(2000 + $urandom_range(0, 20), -1500 + $urandom_range(0, 20), i == 1099);
      quiet = 0;
      for (int s = 0; s < 25; s++) random_scan($urandom_range(1, 12));

      for (int ph = 0; ph < 3; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(CSR_LARGE_RADIUS, 1023);
               write_reg(CSR_SMALL_RADIUS, 1023);
               write_reg(CSR_CLUSTER_GAP, 1023);
            end
            1: begin
               // zero threshold: every later point toggles the cluster
               write_reg(CSR_LARGE_RADIUS, 0);
               write_reg(CSR_SMALL_RADIUS, 0);
               write_reg(CSR_CLUSTER_GAP, 0);
            end
            default: begin
               write_reg(CSR_LARGE_RADIUS, $urandom_range(0, 1023));
               write_reg(CSR_SMALL_RADIUS, $urandom_range(0, 1023));
               write_reg(CSR_CLUSTER_GAP, $urandom_range(0, 1023));
            end
         endcase
         for (int s = 0; s < 25; s++) random_scan($urandom_range(1, 12));
      end

      drain();
      if (errors == 0) begin
         $display("lidar_two_flag_centroid_locator_unit regression: pass");
      end else begin
         $display("lidar_two_flag_centroid_locator_unit regression: fail");
      end
      $finish;
   end

endmodule
